[design/lru_key_value_cache_defines.svh]
// Assertion macros shared by the cache modules.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LKV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lkv assertion failed");
`define LKV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lkv assertion failed");
`else
`define LKV_ASSERT(lbl, clk, rst, prop)
`define LKV_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/lkv_pkg.sv]
// Shared constants and types for the LRU key/value cache.
package lkv_pkg;
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int WORD_W      = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic              MODE_GET  = 1'b0;
  localparam logic              MODE_PUT  = 1'b1;
  localparam logic [WORD_W-1:0] DATA_MISS = '1;
  localparam logic [WORD_W-1:0] DATA_PUT  = '0;

  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_blocked;
  } status_t;
endpackage

[design/lkv_req_if.sv]
// Request channel: get/put transactions into the cache.
interface lkv_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 mode;
  logic signed [lkv_pkg::WORD_W-1:0]    key;
  logic signed [lkv_pkg::WORD_W-1:0]    value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

[design/lkv_resp_if.sv]
// Response channel: one result per request.
interface lkv_resp_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 found;
  logic signed [lkv_pkg::WORD_W-1:0]    data;

  modport source (output valid, output found, output data, input ready);
  modport sink   (input valid, input found, input data, output ready);
endinterface

[design/lkv_cfg_if.sv]
// Configuration write channel for the capacity register.
interface lkv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lkv_pkg::CAP_W-1:0]     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/lru_key_value_cache.sv]
// Fully associative key/value cache with LRU replacement, top level.
// Channels: req (sink) carries mode (0 get, 1 put), key and value; resp
// (source) returns found and data, one transaction per request; cfg (sink)
// writes the 5-bit capacity register, always ready, to be written only
// while the cache is idle. Capacity 0 acts as 1, above 16 acts as 16.
// A get hit returns the stored value, a get miss returns found=0 and -1,
// every put returns data 0 with found telling whether the key was present.
// Flow: a request is accepted, then the parallel key compare over the 16
// entries is registered, then the table/age update runs with the result load.
// The sequencer works on one item at a time and takes no new request until it
// goes back to idle after the update, which waits while resp is stalled; its
// three steps (accept, compare, update) set the pace of requests.
// A finished result sits in the output register; the next request is
// accepted and looked up meanwhile, and its update waits only while resp
// is stalled with a result still pending.
// Reset (rst, synchronous) empties the table, zeroes all ages and occupancy,
// and sets capacity to 16.
module lru_key_value_cache (
  input  logic       clk,
  input  logic       rst,
  lkv_req_if.sink    req,
  lkv_resp_if.source resp,
  lkv_cfg_if.sink    cfg
);
  lkv_pkg::cmd_t    cmd;
  lkv_pkg::status_t status;

  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lkv_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .resp   (resp),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );
endmodule

[design/lkv_ctrl.sv]
// Request sequencer: accept, lookup, update/respond.
`include "lru_key_value_cache_defines.svh"
module lkv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lkv_pkg::status_t status,
  output lkv_pkg::cmd_t    cmd
);
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        if (!status.out_blocked) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `LKV_ASSERT(a_accept_to_lookup, clk, rst, (in_valid && in_ready) |=> (state == S_LOOKUP))
  `LKV_ASSERT(a_lookup_to_update, clk, rst, (state == S_LOOKUP) |=> (state == S_UPDATE))
  `LKV_ASSERT(a_commit_to_idle, clk, rst, cmd.commit |=> (state == S_IDLE))
endmodule

[design/lkv_datapath.sv]
// Entry table, LRU ages, capacity register and result register.
`include "lru_key_value_cache_defines.svh"
module lkv_datapath (
  input  logic             clk,
  input  logic             rst,
  lkv_req_if.sink          req,
  lkv_resp_if.source       resp,
  lkv_cfg_if.sink          cfg,
  input  lkv_pkg::cmd_t    cmd,
  output lkv_pkg::status_t status
);
  localparam int N = lkv_pkg::MAX_ENTRIES;
  localparam int IW = lkv_pkg::IDX_W;
  localparam int OW = lkv_pkg::OCC_W;
  localparam int CW = lkv_pkg::CMP_W;
  localparam int WW = lkv_pkg::WORD_W;

  // current request
  logic          op_mode;
  logic [WW-1:0] op_key;
  logic [WW-1:0] op_value;

  // entry table
  logic [WW-1:0] keys [N];
  logic [WW-1:0] vals [N];
  logic [N-1:0]  valid;
  logic [IW-1:0] age [N];
  logic [IW-1:0] age_next [N];
  logic [OW-1:0] occupancy;
  logic [lkv_pkg::CAP_W-1:0] capacity;

  // lookup results
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] victim_idx;
  logic          full;

  logic          out_valid;
  logic          out_found;
  logic [WW-1:0] out_data;

  logic [N-1:0]  match_vec;
  logic [N-1:0]  victim_vec;
  logic [IW-1:0] hit_idx_c;
  logic [IW-1:0] victim_idx_c;
  logic [IW-1:0] oldest_age;
  logic [CW-1:0] eff_cap;
  logic [IW-1:0] touch_idx;
  logic [IW-1:0] touch_age;
  logic [IW-1:0] wr_idx;
  logic          is_put;
  logic          do_touch;
  logic          do_insert;

  assign cfg.ready = 1'b1;

  assign oldest_age = IW'(occupancy - OW'(1));

  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_vec[i]  = valid[i] && (keys[i] == op_key);
      victim_vec[i] = valid[i] && (age[i] == oldest_age);
    end
    hit_idx_c    = '0;
    victim_idx_c = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match_vec[i]) hit_idx_c = IW'(i);
      if (victim_vec[i]) victim_idx_c = IW'(i);
    end
  end

  // capacity clamped to 1..MAX_ENTRIES
  always_comb begin
    eff_cap = CW'(capacity);
    if (eff_cap == '0) eff_cap = CW'(1);
    if (eff_cap > CW'(N)) eff_cap = CW'(N);
  end

  assign is_put    = (op_mode == lkv_pkg::MODE_PUT);
  assign touch_idx = hit ? hit_idx : victim_idx;
  assign touch_age = age[touch_idx];
  assign wr_idx    = hit ? hit_idx : (full ? victim_idx : occupancy[IW-1:0]);
  assign do_touch  = cmd.commit && (hit || (is_put && full));
  assign do_insert = cmd.commit && is_put && !hit && !full;

  always_comb begin
    for (int j = 0; j < N; j++) begin
      age_next[j] = age[j];
      if (do_touch) begin
        if (IW'(j) == touch_idx) age_next[j] = '0;
        else if (valid[j] && (age[j] < touch_age)) age_next[j] = age[j] + IW'(1);
      end else if (do_insert) begin
        if (IW'(j) == wr_idx) age_next[j] = '0;
        else if (valid[j]) age_next[j] = age[j] + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      occupancy <= '0;
      capacity  <= lkv_pkg::CAP_RESET;
      out_valid <= 1'b0;
      for (int j = 0; j < N; j++) age[j] <= '0;
    end else begin
      if (cfg.valid) capacity <= cfg.data;
      for (int j = 0; j < N; j++) age[j] <= age_next[j];
      if (do_insert) begin
        valid[wr_idx] <= 1'b1;
        occupancy     <= occupancy + OW'(1);
      end
      if (cmd.commit) out_valid <= 1'b1;
      else if (resp.ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= req.mode;
      op_key   <= req.key;
      op_value <= req.value;
    end
    if (cmd.lookup) begin
      hit        <= |match_vec;
      hit_idx    <= hit_idx_c;
      victim_idx <= victim_idx_c;
      full       <= (CW'(occupancy) >= eff_cap);
    end
    if (cmd.commit && is_put) begin
      vals[wr_idx] <= op_value;
      if (!hit) keys[wr_idx] <= op_key;
    end
    if (cmd.commit) begin
      out_found <= hit;
      if (is_put) out_data <= lkv_pkg::DATA_PUT;
      else if (hit) out_data <= vals[hit_idx];
      else out_data <= lkv_pkg::DATA_MISS;
    end
  end

  assign resp.valid         = out_valid;
  assign resp.found         = out_found;
  assign resp.data          = out_data;
  assign status.out_blocked = out_valid && !resp.ready;

  `LKV_ASSERT(a_occ_matches_valid, clk, rst, $countones(valid) == 32'(occupancy))
  `LKV_ASSERT(a_keys_unique, clk, rst, $onehot0(match_vec))
  `LKV_ASSERT(a_one_oldest, clk, rst, (occupancy != '0) |-> $onehot(victim_vec))
endmodule
